[src/assert_macros.svh]
// assertion macros shared by the utf-8 decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/utf8d_pkg.sv]
// shared types and constants of the utf-8 stream decoder
package utf8d_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CodeW = 21;
	localparam int unsigned StatW = 2;
	localparam int unsigned OutDataW = 24;

	// result kinds carried on the output tuser
	typedef enum logic [StatW-1:0] {
		ST_CODE    = 2'd0,
		ST_INVALID = 2'd1,
		ST_END     = 2'd2
	} status_t;

	// byte class boundaries
	localparam logic [ByteW-1:0] AsciiMax = 8'h7F;
	localparam logic [ByteW-1:0] BadLeadMax = 8'hC1;
	localparam logic [ByteW-1:0] Lead2Max = 8'hDF;
	localparam logic [ByteW-1:0] Lead3Max = 8'hEF;
	localparam logic [ByteW-1:0] Lead4Max = 8'hF4;

	// decoder state carried between items
	typedef struct packed {
		logic [1:0]       rem;
		logic [CodeW-1:0] code;
		logic             stopped;
	} dec_state_t;

	// one decoded result
	typedef struct packed {
		logic             valid;
		logic [CodeW-1:0] code_point;
		status_t          status;
		logic             end_of_string;
	} dec_result_t;

endpackage

[src/utf8d_decode.sv]
// combinational next-state and result logic for one input byte
module utf8d_decode (
	input  utf8d_pkg::dec_state_t          st,
	input  logic [utf8d_pkg::ByteW-1:0]    data_byte,
	input  logic                           last_byte,
	output utf8d_pkg::dec_state_t          st_nxt,
	output utf8d_pkg::dec_result_t         res
);

	logic [utf8d_pkg::CodeW-1:0] code_sh;
	logic [1:0]                  rem_dec;
	logic                        fail;

	assign code_sh = {st.code[utf8d_pkg::CodeW-7:0], data_byte[5:0]};
	assign rem_dec = st.rem - 2'd1;

	// byte classification and state update
	always_comb begin
		st_nxt = st;
		fail = 1'b0;
		res.valid = 1'b0;
		res.code_point = '0;
		res.status = utf8d_pkg::ST_CODE;
		res.end_of_string = last_byte;
		if (st.stopped) begin
			// skipping the rest of a broken string
			if (last_byte) begin
				st_nxt = '0;
				res.valid = 1'b1;
				res.status = utf8d_pkg::ST_END;
			end
		end else if (st.rem == 2'd0) begin
			if (data_byte <= utf8d_pkg::AsciiMax) begin
				res.valid = 1'b1;
				res.code_point = {{(utf8d_pkg::CodeW-utf8d_pkg::ByteW){1'b0}}, data_byte};
				if (last_byte) begin
					st_nxt = '0;
				end
			end else if (data_byte <= utf8d_pkg::BadLeadMax ||
					data_byte > utf8d_pkg::Lead4Max) begin
				fail = 1'b1;
			end else begin
				// lead byte opens a multi-byte sequence
				if (data_byte <= utf8d_pkg::Lead2Max) begin
					st_nxt.rem = 2'd1;
					st_nxt.code = {{(utf8d_pkg::CodeW-5){1'b0}}, data_byte[4:0]};
				end else if (data_byte <= utf8d_pkg::Lead3Max) begin
					st_nxt.rem = 2'd2;
					st_nxt.code = {{(utf8d_pkg::CodeW-4){1'b0}}, data_byte[3:0]};
				end else begin
					st_nxt.rem = 2'd3;
					st_nxt.code = {{(utf8d_pkg::CodeW-3){1'b0}}, data_byte[2:0]};
				end
				fail = last_byte;
			end
		end else if (data_byte[7:6] != 2'b10) begin
			fail = 1'b1;
		end else begin
			// continuation byte
			st_nxt.rem = rem_dec;
			st_nxt.code = code_sh;
			if (rem_dec == 2'd0) begin
				res.valid = 1'b1;
				res.code_point = code_sh;
				st_nxt.code = '0;
				if (last_byte) begin
					st_nxt = '0;
				end
			end else begin
				fail = last_byte;
			end
		end
		// invalid sequence: report once, then skip to the end of the string
		if (fail) begin
			res.valid = 1'b1;
			res.code_point = '0;
			res.status = utf8d_pkg::ST_INVALID;
			st_nxt.rem = 2'd0;
			st_nxt.code = '0;
			st_nxt.stopped = ~last_byte;
		end
	end

endmodule

[src/utf8d_out_reg.sv]
// result register feeding the output stream
module utf8d_out_reg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  utf8d_pkg::dec_result_t         res,
	output logic                           free,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [utf8d_pkg::OutDataW-1:0] m_axis_tdata,
	output logic [utf8d_pkg::StatW-1:0]    m_axis_tuser,
	output logic                           m_axis_tlast
);

	logic                        valid_q;
	logic [utf8d_pkg::CodeW-1:0] code_q;
	utf8d_pkg::status_t          status_q;
	logic                        last_q;

	assign free = ~valid_q | m_axis_tready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (free && load) begin
			code_q <= res.code_point;
			status_q <= res.status;
			last_q <= res.end_of_string;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = {{(utf8d_pkg::OutDataW-utf8d_pkg::CodeW){1'b0}}, code_q};
	assign m_axis_tuser = status_q;
	assign m_axis_tlast = last_q;

endmodule

[src/utf8_stream_decoder_unit.sv]
// Streaming UTF-8 decoder: one string byte per input item, code points out.
// Input stream: s_axis_tdata carries the byte, s_axis_tlast marks the last
// byte of a string. Output stream: m_axis_tdata carries the code point,
// m_axis_tuser the status (code point, invalid sequence, end marker only)
// and m_axis_tlast the final result of the string.
// A byte is held in an input register, decoded combinationally against the
// decoder state and written to the result register, so a result is offered
// on the output once it has passed both registers. One byte is taken
// per cycle while the output is drained; bytes inside a sequence give no result.
// Every string ends with exactly one result carrying tlast.
// When the receiver stalls, the result register holds and the input register
// keeps a byte that gives a result; the input side then stops once both are full.
// Reset clears the decoder state, so the first byte after reset opens a
// new string; no item is lost or duplicated under any stall pattern.
module utf8_stream_decoder_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [utf8d_pkg::ByteW-1:0]    s_axis_tdata,  // [7:0] data_byte
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [utf8d_pkg::OutDataW-1:0] m_axis_tdata,  // [20:0] code_point
	output logic [utf8d_pkg::StatW-1:0]    m_axis_tuser,  // [1:0] status
	output logic                           m_axis_tlast
);

	`include "assert_macros.svh"

	logic                          valid_s1;
	logic [utf8d_pkg::ByteW-1:0]   byte_s1;
	logic                          last_s1;
	utf8d_pkg::dec_state_t         st_q;
	utf8d_pkg::dec_state_t         st_nxt;
	utf8d_pkg::dec_result_t        res;
	logic                          out_free;
	logic                          advance;

	// an item leaves the input register when it gives no result or its result can be stored
	assign advance = valid_s1 & (~res.valid | out_free);
	assign s_axis_tready = ~valid_s1 | advance;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	utf8d_decode u_decode (
		.st        (st_q),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.st_nxt    (st_nxt),
		.res       (res)
	);

	utf8d_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance & res.valid),
		.res           (res),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// checks
	`ASSERT_IMPLY(a_stop_clean, clk, arst_n, st_q.stopped, st_q.rem == 2'd0 && st_q.code == '0, "stopped state carries a partial sequence")
	`ASSERT_IMPLY(a_idle_code, clk, arst_n, st_q.rem == 2'd0, st_q.code == '0, "partial code left without a pending sequence")
	`ASSERT_IMPLY(a_end_last, clk, arst_n, m_axis_tvalid && m_axis_tuser == utf8d_pkg::ST_END, m_axis_tlast, "end marker without tlast")
	`ASSERT_IMPLY(a_err_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser != utf8d_pkg::ST_CODE, m_axis_tdata == '0, "non-code result with a nonzero code point")
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(byte_s1) && $stable(last_s1), "held input item changed")

endmodule
